// ----- rtl/rgb_convolution_3x3_clamp_macros.svh -----
// assertion helpers for the checked module
`ifndef RGB_CONVOLUTION_3X3_CLAMP_MACROS_SVH
`define RGB_CONVOLUTION_3X3_CLAMP_MACROS_SVH

// same-cycle implication
`define RGBC_ASSERT_NOW(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("rgbc same-cycle check failed");

// next-cycle implication
`define RGBC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("rgbc next-cycle check failed");

`endif

// ----- rtl/rgbc_pkg.sv -----
package rgbc_pkg;

   localparam int PIX_BITS       = 8;
   localparam int ROW_BITS       = 12;
   localparam int COL_BITS       = 11;
   localparam int WIDTH_BITS     = 12;
   localparam int HEIGHT_BITS    = 13;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;
   localparam int ACC_BITS       = 12;

   localparam int DEFAULT_MAX_WIDTH = 2048;
   localparam int MAX_HEIGHT        = 4096;
   localparam int MIN_DIM           = 4;
   localparam int WIDTH_RESET       = 640;
   localparam int HEIGHT_RESET      = 480;
   localparam int CLAMP_MAX         = 255;
   localparam int BORDER            = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_BITS'(1);

   typedef struct packed {
      logic [PIX_BITS-1:0] blue;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] red;
   } pixel_type;

   typedef logic signed [2:0] coef_type;

   // row i of the window, column offset j back from the newest column
   localparam coef_type KERNEL [3][3] = '{
      '{coef_type'(-2), coef_type'(-1), coef_type'(-2)},
      '{coef_type'(-1), coef_type'(1),  coef_type'(1)},
      '{coef_type'(2),  coef_type'(1),  coef_type'(2)}
   };

   typedef struct packed {
      pixel_type           pixel;
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic                filtered;
      logic                last;
   } result_type;

endpackage

// ----- rtl/rgbc_if.sv -----
interface rgbc_req_if;
   import rgbc_pkg::*;
   logic                valid;
   logic                ready;
   logic [PIX_BITS-1:0] in_red;
   logic [PIX_BITS-1:0] in_green;
   logic [PIX_BITS-1:0] in_blue;
   modport source (output valid, in_red, in_green, in_blue, input ready);
   modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface rgbc_rsp_if;
   import rgbc_pkg::*;
   logic                valid;
   logic                ready;
   logic [PIX_BITS-1:0] out_red;
   logic [PIX_BITS-1:0] out_green;
   logic [PIX_BITS-1:0] out_blue;
   logic [ROW_BITS-1:0] out_row;
   logic [COL_BITS-1:0] out_col;
   logic                was_filtered;
   logic                last_of_run;
   modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
                   was_filtered, last_of_run, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_row, out_col,
                 was_filtered, last_of_run, output ready);
endinterface

interface rgbc_csr_if;
   import rgbc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/rgbc_ram.sv -----
module rgbc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/rgbc_filter.sv -----
module rgbc_filter (
   input  rgbc_pkg::pixel_type taps [3][3],
   output rgbc_pkg::pixel_type filtered
);
   import rgbc_pkg::*;

   logic [3*PIX_BITS-1:0] result;

   always_comb begin
      logic signed [ACC_BITS-1:0] acc;
      logic [3*PIX_BITS-1:0]      flat;
      logic [PIX_BITS-1:0]        sample;
      result = '0;
      for (int ch = 0; ch < 3; ch++) begin
         acc = '0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               flat   = taps[i][j];
               sample = flat[ch*PIX_BITS +: PIX_BITS];
               acc    = acc + ACC_BITS'(KERNEL[i][j]) * ACC_BITS'($signed({1'b0, sample}));
            end
         end
         // saturate to the pixel range
         if (acc[ACC_BITS-1]) begin
            result[ch*PIX_BITS +: PIX_BITS] = '0;
         end else if (acc > ACC_BITS'(CLAMP_MAX)) begin
            result[ch*PIX_BITS +: PIX_BITS] = PIX_BITS'(CLAMP_MAX);
         end else begin
            result[ch*PIX_BITS +: PIX_BITS] = acc[PIX_BITS-1:0];
         end
      end
   end

   assign filtered = result;
endmodule

// ----- rtl/rgb_convolution_3x3_clamp.sv -----
// Streaming 3x3 RGB filter with border passthrough. Pixels enter in raster
// order, one request per cycle unless stalled; the two previous rows sit in
// two line RAMs read one column ahead, the six-pixel window in flip-flops.
// A request on row 2 or later puts its result into a four-entry output queue
// in the cycle after acceptance; rows 0 and 1 give nothing. On the last row of
// a frame each request gives three results, which leave through the single
// output port one per cycle while rsp.ready is high. A request waits while
// the queue holds more than one entry. After any csr write the request side
// pauses in the next cycle while the line RAM read address settles to the new
// geometry. Line RAM contents are undefined after reset and are not cleared.
`include "rgb_convolution_3x3_clamp_macros.svh"

module rgb_convolution_3x3_clamp #(
   parameter int MAX_WIDTH = rgbc_pkg::DEFAULT_MAX_WIDTH
) (
   input logic       clock,
   input logic       reset,
   rgbc_csr_if.sink  csr,
   rgbc_req_if.sink  req,
   rgbc_rsp_if.source rsp
);
   import rgbc_pkg::*;

   localparam int ColBits   = $clog2(MAX_WIDTH);
   localparam int WNeed     = $clog2(MAX_WIDTH + 1);
   localparam int WBits     = (WNeed > WIDTH_BITS) ? WNeed : WIDTH_BITS;
   localparam int BufDepth  = 4;
   localparam int PtrBits   = $clog2(BufDepth);
   localparam int CountBits = $clog2(BufDepth + 1);

   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic                   settle_ff;
   logic [ColBits-1:0]     col_ff, col_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   pixel_type              win_ff [6];
   result_type             buf_ff [BufDepth];
   logic [PtrBits-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CountBits-1:0]   count_ff, count_in;

   logic [WBits-1:0]       w_raw, w_eff, col_plus;
   logic [HEIGHT_BITS-1:0] h_eff, row_step, row_plus;
   logic                   col_wrap, end_row;
   logic [ColBits-1:0]     cur_col, rd_addr;
   logic [ROW_BITS-1:0]    cur_row;
   logic                   accept, pop, csr_fire;
   logic                   emit_any, last_row, filt;
   logic [CountBits-1:0]   push_count;

   pixel_type              old_px, new_px, cur_px, filt_px;
   pixel_type              taps [3][3];
   result_type             res0, res1, res2;

   // effective geometry
   always_comb begin
      w_raw = WBits'(width_ff);
      if (w_raw < WBits'(MIN_DIM)) begin
         w_eff = WBits'(MIN_DIM);
      end else if (w_raw > WBits'(MAX_WIDTH)) begin
         w_eff = WBits'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      if (height_ff < HEIGHT_BITS'(MIN_DIM)) begin
         h_eff = HEIGHT_BITS'(MIN_DIM);
      end else if (height_ff > HEIGHT_BITS'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // position of the pending request and of the one after it
   always_comb begin
      col_wrap = WBits'(col_ff) >= w_eff;
      cur_col  = col_wrap ? '0 : col_ff;
      row_step = HEIGHT_BITS'(row_ff) + HEIGHT_BITS'(col_wrap);
      cur_row  = (row_step >= h_eff) ? '0 : row_step[ROW_BITS-1:0];

      col_plus = WBits'(cur_col) + WBits'(1);
      end_row  = col_plus >= w_eff;
      row_plus = HEIGHT_BITS'(cur_row) + HEIGHT_BITS'(1);
      if (end_row) begin
         col_in = '0;
         row_in = (row_plus >= h_eff) ? '0 : row_plus[ROW_BITS-1:0];
      end else begin
         col_in = col_plus[ColBits-1:0];
         row_in = cur_row;
      end
   end

   assign csr.ready = 1'b1;
   assign csr_fire  = csr.valid && csr.ready;
   assign req.ready = !settle_ff && (count_ff <= CountBits'(1));
   assign accept    = req.valid && req.ready;
   assign rsp.valid = count_ff != '0;
   assign pop       = rsp.valid && rsp.ready;

   // read one column ahead so the line data is ready when the request lands
   assign rd_addr = accept ? col_in : cur_col;

   assign cur_px.red   = req.in_red;
   assign cur_px.green = req.in_green;
   assign cur_px.blue  = req.in_blue;

   rgbc_ram #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_older_line (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (cur_col),
      .wr_data (new_px),
      .rd_addr (rd_addr),
      .rd_data (old_px)
   );

   rgbc_ram #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_newer_line (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (cur_col),
      .wr_data (cur_px),
      .rd_addr (rd_addr),
      .rd_data (new_px)
   );

   always_comb begin
      taps[0][0] = old_px;
      taps[0][1] = win_ff[0];
      taps[0][2] = win_ff[3];
      taps[1][0] = new_px;
      taps[1][1] = win_ff[1];
      taps[1][2] = win_ff[4];
      taps[2][0] = cur_px;
      taps[2][1] = win_ff[2];
      taps[2][2] = win_ff[5];
   end

   rgbc_filter u_filter (
      .taps     (taps),
      .filtered (filt_px)
   );

   always_comb begin
      emit_any = cur_row >= ROW_BITS'(2);
      last_row = HEIGHT_BITS'(cur_row) == (h_eff - HEIGHT_BITS'(1));
      filt     = ((HEIGHT_BITS'(cur_row) - HEIGHT_BITS'(2)) <= (h_eff - HEIGHT_BITS'(4)))
                 && (WBits'(cur_col) >= WBits'(BORDER));

      res0.pixel    = filt ? filt_px : old_px;
      res0.row      = cur_row - ROW_BITS'(2);
      res0.col      = COL_BITS'(cur_col);
      res0.filtered = filt;
      res0.last     = !last_row;

      res1.pixel    = new_px;
      res1.row      = cur_row - ROW_BITS'(1);
      res1.col      = COL_BITS'(cur_col);
      res1.filtered = 1'b0;
      res1.last     = 1'b0;

      res2.pixel    = cur_px;
      res2.row      = cur_row;
      res2.col      = COL_BITS'(cur_col);
      res2.filtered = 1'b0;
      res2.last     = 1'b1;

      if (accept && emit_any) begin
         push_count = last_row ? CountBits'(3) : CountBits'(1);
      end else begin
         push_count = '0;
      end
      count_in = count_ff + push_count - CountBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_BITS'(WIDTH_RESET);
         height_ff <= HEIGHT_BITS'(HEIGHT_RESET);
         settle_ff <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         settle_ff <= csr_fire;
         if (csr_fire) begin
            unique case (csr.index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr.data[WIDTH_BITS-1:0];
               CSR_IMAGE_HEIGHT: height_ff <= csr.data[HEIGHT_BITS-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            col_ff    <= col_in;
            row_ff    <= row_in;
            win_ff[3] <= win_ff[0];
            win_ff[4] <= win_ff[1];
            win_ff[5] <= win_ff[2];
            win_ff[0] <= old_px;
            win_ff[1] <= new_px;
            win_ff[2] <= cur_px;
         end
         wr_ptr_ff <= wr_ptr_ff + PtrBits'(push_count);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrBits'(1);
         end
         count_ff <= count_in;
      end
   end

   // output queue payload
   always_ff @(posedge clock) begin
      if (accept && emit_any) begin
         buf_ff[wr_ptr_ff] <= res0;
         if (last_row) begin
            buf_ff[wr_ptr_ff + PtrBits'(1)] <= res1;
            buf_ff[wr_ptr_ff + PtrBits'(2)] <= res2;
         end
      end
   end

   assign rsp.out_red      = buf_ff[rd_ptr_ff].pixel.red;
   assign rsp.out_green    = buf_ff[rd_ptr_ff].pixel.green;
   assign rsp.out_blue     = buf_ff[rd_ptr_ff].pixel.blue;
   assign rsp.out_row      = buf_ff[rd_ptr_ff].row;
   assign rsp.out_col      = buf_ff[rd_ptr_ff].col;
   assign rsp.was_filtered = buf_ff[rd_ptr_ff].filtered;
   assign rsp.last_of_run  = buf_ff[rd_ptr_ff].last;

   `RGBC_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, count_ff <= CountBits'(BufDepth))
   `RGBC_ASSERT_NEXT(a_csr_pause, clock, reset, csr_fire, !req.ready)
   `RGBC_ASSERT_NEXT(a_result_follows, clock, reset, accept && emit_any, rsp.valid)
   `RGBC_ASSERT_NOW(a_run_queued, clock, reset, rsp.valid && !rsp.last_of_run, count_ff >= CountBits'(2))

endmodule

// ----- sim/rgb_convolution_3x3_clamp_tb.sv -----
module rgb_convolution_3x3_clamp_tb;
   import rgbc_pkg::*;

   localparam int LINE_DEPTH        = DEFAULT_MAX_WIDTH;
   localparam int SETTLE_CYCLES     = 8;
   localparam int RANDOM_ITEMS      = 170;
   localparam int ERROR_PRINT_LIMIT = 100;

   logic clock = 1'b0;
   logic reset;

   rgbc_csr_if csr_bus ();
   rgbc_req_if req_bus ();
   rgbc_rsp_if rsp_bus ();

   rgb_convolution_3x3_clamp u_dut (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always #5 clock = ~clock;

   // filter state as seen from the pixel stream
   logic [WIDTH_BITS-1:0]  geom_width;
   logic [HEIGHT_BITS-1:0] geom_height;
   pixel_type              line_older [LINE_DEPTH];
   pixel_type              line_newer [LINE_DEPTH];
   pixel_type              window [6];
   int unsigned            row_pos;
   int unsigned            col_pos;

   result_type pending_pixels [$];
   int         error_count;
   int         items_sent;
   int         req_idle_pct;
   int         rsp_idle_pct;
   int         rsp_hold_cycles;

   function automatic int unsigned active_width();
      int unsigned w = geom_width;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > DEFAULT_MAX_WIDTH) w = DEFAULT_MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned active_height();
      int unsigned h = geom_height;
      if (h < MIN_DIM) h = MIN_DIM;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
   endfunction

   function automatic void apply_register(logic [CSR_INDEX_BITS-1:0] index,
                                          logic [CSR_DATA_BITS-1:0] data);
      if (index == CSR_IMAGE_WIDTH) geom_width = data[WIDTH_BITS-1:0];
      else if (index == CSR_IMAGE_HEIGHT) geom_height = data[HEIGHT_BITS-1:0];
   endfunction

   // taps[j][i]: column c-j, row r-2+i
   function automatic logic [PIX_BITS-1:0] filter_channel(pixel_type taps [3][3], int ch);
      int acc = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            acc += int'(KERNEL[i][j]) * int'(taps[j][i][8*ch +: 8]);
      if (acc < 0) acc = 0;
      if (acc > CLAMP_MAX) acc = CLAMP_MAX;
      return PIX_BITS'(acc);
   endfunction

   function automatic void push_result(pixel_type px, int unsigned row, int unsigned col,
                                       logic filt, logic last);
      result_type rec;
      rec.pixel    = px;
      rec.row      = ROW_BITS'(row);
      rec.col      = COL_BITS'(col);
      rec.filtered = filt;
      rec.last     = last;
      pending_pixels.insert(pending_pixels.size(), rec);
   endfunction

   function automatic void predict_pixel(pixel_type cur);
      int unsigned w, h, r, c;
      pixel_type   old_px, new_px, res;
      pixel_type   taps [3][3];
      logic        last_row, filt;
      w = active_width();
      h = active_height();
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;
      old_px = line_older[c];
      new_px = line_newer[c];
      taps[0][0] = old_px;
      taps[0][1] = new_px;
      taps[0][2] = cur;
      for (int k = 0; k < 3; k++) begin
         taps[1][k] = window[k];
         taps[2][k] = window[k+3];
      end
      if (r >= 2) begin
         last_row = (r == h - 1);
         filt = (r - 2 <= h - 4) && (c >= BORDER);
         if (filt) begin
            for (int ch = 0; ch < 3; ch++) res[8*ch +: 8] = filter_channel(taps, ch);
         end else begin
            res = old_px;
         end
         push_result(res, r - 2, c, filt, !last_row);
         if (last_row) begin
            push_result(new_px, r - 1, c, 1'b0, 1'b0);
            push_result(cur, r, c, 1'b0, 1'b1);
         end
      end
      for (int k = 0; k < 3; k++) window[k+3] = window[k];
      window[0] = old_px;
      window[1] = new_px;
      window[2] = cur;
      line_older[c] = new_px;
      line_newer[c] = cur;
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      for (int ch = 0; ch < 3; ch++) begin
         case ($urandom_range(0, 9))
            0: px[8*ch +: 8] = '0;
            1: px[8*ch +: 8] = '1;
            default: px[8*ch +: 8] = PIX_BITS'($urandom);
         endcase
      end
      return px;
   endfunction

   // rows chosen so that one filtered pixel clamps high and low
   function automatic pixel_type pattern_pixel(int unsigned row, int unsigned col);
      case (row)
         0: return pixel_type'{blue: 8'h55, green: 8'hFF, red: 8'h00};
         1: return pixel_type'{blue: 8'h01, green: 8'h80, red: 8'h80};
         2: return pixel_type'{blue: 8'hAA, green: 8'h00, red: 8'hFF};
         default: begin
            if (col == 0) return pixel_type'{blue: 8'h00, green: 8'h00, red: 8'h00};
            if (col == 1) return pixel_type'{blue: 8'hFF, green: 8'hFF, red: 8'hFF};
            return random_pixel();
         end
      endcase
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 10;
         default: return 30;
      endcase
   endfunction

   task automatic drive_pixel(pixel_type px);
      req_bus.valid    <= 1'b1;
      req_bus.in_red   <= px.red;
      req_bus.in_green <= px.green;
      req_bus.in_blue  <= px.blue;
      do @(posedge clock); while (!req_bus.ready);
      predict_pixel(px);
      items_sent++;
      if (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic drive_random(int count);
      repeat (count) drive_pixel(random_pixel());
   endtask

   task automatic finish_frame();
      do drive_pixel(random_pixel()); while (row_pos != 0 || col_pos != 0);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_send(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      apply_register(index, data);
   endtask

   // upper data bits above each register are junk and must be dropped
   task automatic write_geometry(int unsigned width_value, int unsigned height_value);
      wait_drained();
      csr_send(CSR_IMAGE_WIDTH, {4'($urandom), 12'(width_value)});
      csr_send(CSR_IMAGE_HEIGHT, {3'($urandom), 13'(height_value)});
      if ($urandom_range(0, 4) == 0)
         csr_send(CSR_INDEX_BITS'($urandom_range(2, 255)), CSR_DATA_BITS'($urandom));
      csr_bus.valid <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      for (int unsigned col = 0; col < 6; col++) drive_pixel(pattern_pixel(0, col));
   endtask

   task automatic test_clamp_and_borders();
      // both registers below range, so the frame is 4 x 4
      write_geometry(0, 2);
      for (int unsigned row = 1; row < 4; row++)
         for (int unsigned col = 0; col < 4; col++) drive_pixel(pattern_pixel(row, col));
   endtask

   task automatic test_geometry_change();
      write_geometry(8, 8);
      drive_random(22);
      // narrower width while mid row: next request opens a new row
      write_geometry(5, 8);
      drive_random(13);
      // row count beyond the new height: wraps to row 0
      write_geometry(5, 4);
      finish_frame();
   endtask

   task automatic test_backpressure();
      int saved_idle;
      saved_idle = req_idle_pct;
      write_geometry(6, 5);
      req_idle_pct = 0;
      rsp_hold_cycles = 120;
      finish_frame();
      drive_random(15);
      wait_drained();
      finish_frame();
      req_idle_pct = saved_idle;
   endtask

   task automatic test_extreme_geometry();
      req_idle_pct = 3;
      rsp_idle_pct = 3;
      // width above range and height below range: widest row, shortest frame
      write_geometry(4095, 3);
      drive_random(10);
      // narrower width mid row opens row 1, height saturates high
      write_geometry(4, 8191);
      drive_random(20);
      // row count beyond the new height: wraps to row 0
      write_geometry(4, 3);
      finish_frame();
   endtask

   task automatic test_random_frames();
      int first;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         req_idle_pct = pick_idle_pct();
         rsp_idle_pct = pick_idle_pct();
         // width may only grow at a frame boundary
         if (row_pos == 0 && col_pos == 0)
            write_geometry($urandom_range(0, 12), $urandom_range(0, 8));
         else
            write_geometry($urandom_range(0, active_width()), $urandom_range(0, 8));
         if ($urandom_range(0, 4) == 0) drive_random($urandom_range(1, 30));
         else finish_frame();
      end
   endtask

   task automatic test_quiet_tail();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      finish_frame();
      write_geometry(7, 5);
      finish_frame();
   endtask

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= ERROR_PRINT_LIMIT)
            $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   initial begin
      result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_pixels.size() == 0) begin
               error_count++;
               if (error_count <= ERROR_PRINT_LIMIT)
                  $error("unexpected result at row %0d col %0d", rsp_bus.out_row,
                         rsp_bus.out_col);
            end else begin
               want = pending_pixels.pop_front();
               check_field("out_red", want.pixel.red, rsp_bus.out_red);
               check_field("out_green", want.pixel.green, rsp_bus.out_green);
               check_field("out_blue", want.pixel.blue, rsp_bus.out_blue);
               check_field("out_row", want.row, rsp_bus.out_row);
               check_field("out_col", want.col, rsp_bus.out_col);
               check_field("was_filtered", want.filtered, rsp_bus.was_filtered);
               check_field("last_of_run", want.last, rsp_bus.last_of_run);
            end
         end
      end
   end

   initial begin
      int hold;
      rsp_bus.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            hold = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else if (rsp_idle_pct > 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #40_000_000;
      $display("FAIL rgb_convolution_3x3_clamp");
      $finish;
   end

   initial begin
      error_count     = 0;
      items_sent      = 0;
      req_idle_pct    = 10;
      rsp_idle_pct    = 10;
      rsp_hold_cycles = 0;
      geom_width      = WIDTH_BITS'(WIDTH_RESET);
      geom_height     = HEIGHT_BITS'(HEIGHT_RESET);
      row_pos         = 0;
      col_pos         = 0;
      for (int k = 0; k < 6; k++) window[k] = '0;
      for (int k = 0; k < LINE_DEPTH; k++) begin
         line_older[k] = '0;
         line_newer[k] = '0;
      end
      req_bus.valid    = 1'b0;
      req_bus.in_red   = '0;
      req_bus.in_green = '0;
      req_bus.in_blue  = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = '0;
      csr_bus.data     = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_clamp_and_borders();
      test_geometry_change();
      test_backpressure();
      test_extreme_geometry();
      test_random_frames();
      test_quiet_tail();
      wait_drained();

      if (error_count == 0) begin
         $display("PASS rgb_convolution_3x3_clamp");
      end else begin
         $display("FAIL rgb_convolution_3x3_clamp");
      end
      $finish;
   end

endmodule
